FILE: design/skt_pkg.sv
// Package for the sorted key table: sizes, codes and beat payload types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package skt_pkg;
    localparam int Capacity   = 128;
    localparam int KeyBytes   = 24;
    localparam int IdxW       = $clog2(Capacity);
    localparam int CntW       = $clog2(Capacity + 1);
    localparam logic [15:0] MissingReset = 16'd10000;

    localparam logic [1:0] KindClear  = 2'd0;
    localparam logic [1:0] KindInsert = 2'd1;

    localparam logic [2:0] StFound    = 3'd0;
    localparam logic [2:0] StInserted = 3'd1;
    localparam logic [2:0] StNotFound = 3'd2;
    localparam logic [2:0] StFull     = 3'd3;
    localparam logic [2:0] StCleared  = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] key_hi;
        logic [63:0] key_mid;
        logic [63:0] key_lo;
        logic [15:0] value_in;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] value_out;
        logic [2:0]  status;
        logic [7:0]  count_out;
    } t_out_beat;

    typedef logic [191:0] t_key;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input, canonicalize key, init search bounds
        logic rd_mid;     // issue memory read at mid
        logic cmp;        // compare read entry, narrow bounds
        logic shift_rd;   // read entry at shift pointer - 1
        logic shift_wr;   // write it one place up, step pointer down
        logic place;      // write new entry at start, bump count
        logic clear;      // zero the count
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       search_done; // start == end
        logic       hit;         // last compare was equal
        logic       shift_done;  // pointer reached start
        logic       full;
        logic [1:0] kind;
    } t_sts;

    // Force bytes after the first zero byte (and beyond KeyBytes) to zero.
    function automatic t_key canon(input t_key raw);
        t_key   k;
        logic   ended;
        logic [7:0] b;
        k = '0;
        ended = 1'b0;
        for (int p = 0; p < 24; p++) begin
            b = raw[191 - 8*p -: 8];
            if (p >= KeyBytes) ended = 1'b1;
            if (!ended) k[191 - 8*p -: 8] = b;
            if (b == 8'd0) ended = 1'b1;
        end
        return k;
    endfunction
endpackage
`default_nettype wire

FILE: design/skt_datapath.sv
// Datapath of the sorted key table: entry memory, search bounds, shift pointer.
// Depends on skt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module skt_datapath (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire skt_pkg::t_cmd   i_cmd,
    input  wire skt_pkg::t_in_beat i_beat,
    input  wire logic [15:0]     i_missing,
    output skt_pkg::t_sts        o_sts,
    output skt_pkg::t_out_beat   o_res
);
    localparam int IdxW = skt_pkg::IdxW;
    localparam int CntW = skt_pkg::CntW;

    // entry memory: key and value side by side
    logic [207:0] r_mem [skt_pkg::Capacity];
    logic [207:0] r_rd;

    logic [CntW-1:0] r_count;
    logic [CntW-1:0] r_start, r_end, r_ptr;
    logic [CntW-1:0] mid;
    skt_pkg::t_key   r_key;
    logic [15:0]     r_vin;
    logic [1:0]      r_kind;
    logic            r_hit;
    logic [CntW:0]   sum;
    logic [IdxW-1:0] rd_addr;
    logic [IdxW-1:0] wr_addr;
    logic [207:0]    wr_data;

    assign sum = {1'b0, r_start} + {1'b0, r_end};
    assign mid = sum[CntW:1];

    // memory port: one read, one write per cycle
    assign rd_addr = i_cmd.rd_mid ? mid[IdxW-1:0] : IdxW'(r_ptr - CntW'(1));
    assign wr_addr = i_cmd.place ? r_start[IdxW-1:0] : r_ptr[IdxW-1:0];
    assign wr_data = i_cmd.place ? {r_key, r_vin} : r_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_mid || i_cmd.shift_rd) r_rd <= r_mem[rd_addr];
        if (i_cmd.shift_wr || i_cmd.place)  r_mem[wr_addr] <= wr_data;
    end

    // search bounds, count and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_hit   <= 1'b0;
        end else begin
            if (i_cmd.clear) r_count <= '0;
            if (i_cmd.load) begin
                r_key   <= skt_pkg::canon({i_beat.key_hi, i_beat.key_mid, i_beat.key_lo});
                r_vin   <= i_beat.value_in;
                r_kind  <= i_beat.kind;
                r_start <= '0;
                r_end   <= r_count;
                r_ptr   <= r_count;
                r_hit   <= 1'b0;
            end
            if (i_cmd.cmp) begin
                if (r_key == r_rd[207:16]) r_hit <= 1'b1;
                else if (r_key < r_rd[207:16]) r_end <= mid;
                else r_start <= mid + CntW'(1);
            end
            if (i_cmd.shift_wr) r_ptr <= r_ptr - CntW'(1);
            if (i_cmd.place) r_count <= r_count + CntW'(1);
        end
    end

    assign o_sts.search_done = (r_start == r_end);
    assign o_sts.hit         = r_hit;
    assign o_sts.shift_done  = (r_ptr == r_start);
    assign o_sts.full        = (r_count == CntW'(skt_pkg::Capacity));
    assign o_sts.kind        = r_kind;

    // result fields, valid once the controller finishes
    // pointer still at count means nothing was placed: table was full
    always_comb begin
        o_res.count_out = 8'(r_count);
        if (r_kind == skt_pkg::KindClear) begin
            o_res.value_out = 16'd0;
            o_res.status    = skt_pkg::StCleared;
            o_res.count_out = 8'd0;
        end else if (r_hit) begin
            o_res.value_out = r_rd[15:0];
            o_res.status    = skt_pkg::StFound;
        end else if (r_kind != skt_pkg::KindInsert) begin
            o_res.value_out = i_missing;
            o_res.status    = skt_pkg::StNotFound;
        end else if (r_count == r_ptr) begin
            o_res.value_out = i_missing;
            o_res.status    = skt_pkg::StFull;
        end else begin
            o_res.value_out = r_vin;
            o_res.status    = skt_pkg::StInserted;
        end
    end
endmodule
`default_nettype wire

FILE: design/skt_ctrl.sv
// Controller of the sorted key table: sequences search, shift and placement.
// Depends on skt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module skt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    input  wire skt_pkg::t_sts i_sts,
    output skt_pkg::t_cmd      o_cmd,
    output logic               o_res_load
);
    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_CMP, S_SHRD, S_SHWR, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   done_go;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        done_go    = 1'b0;
        case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.load = 1'b1;
                n_state = S_SEARCH;
            end
            S_SEARCH: begin
                if (i_sts.kind == skt_pkg::KindClear) begin
                    o_cmd.clear = 1'b1;
                    n_state = S_DONE;
                end else if (i_sts.hit) begin
                    n_state = S_DONE;
                end else if (i_sts.search_done) begin
                    if (i_sts.kind != skt_pkg::KindInsert || i_sts.full) n_state = S_DONE;
                    else n_state = S_SHRD;
                end else begin
                    o_cmd.rd_mid = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state = S_SEARCH;
            end
            S_SHRD: begin
                if (i_sts.shift_done) begin
                    o_cmd.place = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.shift_rd = 1'b1;
                    n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                o_cmd.shift_wr = 1'b1;
                n_state = S_SHRD;
            end
            S_DONE: if (!r_out_valid) done_go = 1'b1;
            default: n_state = S_IDLE;
        endcase
        if (done_go) n_state = S_IDLE;
    end
    assign o_res_load = done_go;

    // state and output-valid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (done_go) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end
endmodule
`default_nettype wire

FILE: design/sorted_key_table_find_or_insert_core.sv
// Sorted key table, find or insert: a binary search over the sorted entries,
// then on insert each entry above the insertion point is shifted up one place
// through the entry memory before the new entry is placed.
// One item at a time. Synchronous active-low reset empties the table and sets
// missing_value to 10000; entry memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sorted_key_table_find_or_insert_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire skt_pkg::t_in_beat  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output skt_pkg::t_out_beat      o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [15:0]        i_cfg_data
);
    skt_pkg::t_cmd      cmd;
    skt_pkg::t_sts      sts;
    skt_pkg::t_out_beat res;
    logic               res_load;
    logic [15:0]        r_missing;
    skt_pkg::t_out_beat r_out;

    assign o_cfg_ready = 1'b1;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_missing <= skt_pkg::MissingReset;
        else if (i_cfg_valid) r_missing <= i_cfg_data;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (res_load) r_out <= res;
    end
    assign o_out_data = r_out;

    skt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall), .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall), .i_sts(sts), .o_cmd(cmd), .o_res_load(res_load)
    );

    skt_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_beat(i_in_data),
        .i_missing(r_missing), .o_sts(sts), .o_res(res)
    );
endmodule
`default_nettype wire

FILE: design/skt_checker.sv
// Port-level checker for the sorted key table, bound to the top level.
// Depends on skt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module skt_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire skt_pkg::t_out_beat o_out_data
);
    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");
    // an accepted beat is not answered in the next cycle
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result too early");
    // a clear reports zero count
    a_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == skt_pkg::StCleared |-> o_out_data.count_out == 8'd0)
        else $error("clear with nonzero count");
    // count never exceeds capacity
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.count_out <= 8'(skt_pkg::Capacity))
        else $error("count beyond capacity");
endmodule

bind sorted_key_table_find_or_insert_core skt_checker u_chk (.*);
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the sorted key table find-or-insert core.
// Depends on skt_pkg and sorted_key_table_find_or_insert_core.
`timescale 1ns / 1ps
module testbench;
    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    skt_pkg::t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    skt_pkg::t_out_beat o_out_data;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic [15:0] i_cfg_data;

    localparam logic [1:0] KindLookup = 2'd2;
    localparam logic [1:0] KindSpare  = 2'd3;
    localparam int WatchLimit = 20000;

    sorted_key_table_find_or_insert_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the table
    skt_pkg::t_key tbl_keys[skt_pkg::Capacity];
    logic [15:0]   tbl_vals[skt_pkg::Capacity];
    int            tbl_count;
    logic [15:0]   miss_val;

    skt_pkg::t_in_beat  pending_items[$];
    skt_pkg::t_out_beat expected_results[$];
    int  errors;
    int  idle_cycles;
    bit  quiet;        // no random idling in the last part
    bit  hold_long;    // request for a long receiver hold-off
    int  src_gap;
    int  snk_gap;
    int  hold_left;
    logic o_in_stall_q;   // stall as sampled at the last rising clock edge
    bit   hold_done;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Predict the one result of an item and update the shadow table
    function automatic skt_pkg::t_out_beat table_step(input skt_pkg::t_in_beat it);
        skt_pkg::t_out_beat r;
        skt_pkg::t_key k;
        int lo, hi, mid;
        k = skt_pkg::canon({it.key_hi, it.key_mid, it.key_lo});
        r = '0;
        if (it.kind == skt_pkg::KindClear) begin
            tbl_count = 0;
            r.status = skt_pkg::StCleared;
            return r;
        end
        lo = 0;
        hi = tbl_count;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (k == tbl_keys[mid]) begin
                r.value_out = tbl_vals[mid];
                r.status = skt_pkg::StFound;
                r.count_out = 8'(tbl_count);
                return r;
            end
            if (k < tbl_keys[mid]) hi = mid;
            else lo = mid + 1;
        end
        if (it.kind != skt_pkg::KindInsert) begin
            r.value_out = miss_val;
            r.status = skt_pkg::StNotFound;
        end else if (tbl_count >= skt_pkg::Capacity) begin
            r.value_out = miss_val;
            r.status = skt_pkg::StFull;
        end else begin
            for (int i = tbl_count; i > lo; i--) begin
                tbl_keys[i] = tbl_keys[i-1];
                tbl_vals[i] = tbl_vals[i-1];
            end
            tbl_keys[lo] = k;
            tbl_vals[lo] = it.value_in;
            tbl_count++;
            r.value_out = it.value_in;
            r.status = skt_pkg::StInserted;
        end
        r.count_out = 8'(tbl_count);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // Style 0 keys come from a small alphabet so that hits and collisions are common
    function automatic skt_pkg::t_key pick_key(input int style);
        skt_pkg::t_key k;
        int len;
        k = '0;
        case (style)
            0: begin
                len = $urandom_range(1, 3);
                for (int p = 0; p < len; p++) k[191 - 8*p -: 8] = 8'($urandom_range(97, 100));
            end
            1: begin
                len = $urandom_range(1, 24);
                for (int p = 0; p < len; p++) k[191 - 8*p -: 8] = 8'($urandom_range(1, 255));
            end
            default: k = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        endcase
        return k;
    endfunction

    task automatic add_item(input logic [1:0] kd, input skt_pkg::t_key k,
                            input logic [15:0] v);
        skt_pkg::t_in_beat it;
        it.kind = kd;
        {it.key_hi, it.key_mid, it.key_lo} = k;
        it.value_in = v;
        pending_items.push_back(it);
    endtask

    task automatic wait_drain();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_missing(input logic [15:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        miss_val = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int n);
        int r, style;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            style = (r < 70) ? 0 : (r < 90) ? 1 : 2;
            if (r < 2) add_item(skt_pkg::KindClear, pick_key(style), 16'($urandom));
            else if (r < 55) add_item(skt_pkg::KindInsert, pick_key(style), 16'($urandom));
            else if (r < 95) add_item(KindLookup, pick_key(style), 16'($urandom));
            else add_item(KindSpare, pick_key(style), 16'($urandom));
        end
    endtask

    // Stimulus and phases
    initial begin
        skt_pkg::t_key k;
        errors = 0;
        tbl_count = 0;
        miss_val = skt_pkg::MissingReset;
        quiet = 1'b0;
        hold_long = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, field extremes, embedded zero byte, kind 3
        add_item(KindLookup, '0, 16'hFFFF);
        add_item(skt_pkg::KindInsert, '0, 16'h0000);
        add_item(skt_pkg::KindInsert, '1, 16'hFFFF);
        add_item(skt_pkg::KindInsert, '1, 16'h1234);
        k = '1;
        k[191-8*3 -: 8] = 8'h00;
        add_item(skt_pkg::KindInsert, k, 16'h00AA);
        k[191-8*3 -: 8] = 8'h41;
        add_item(KindLookup, k, 16'h0);
        k = '1; k[191-8*3 -: 8] = 8'h00; k[50:0] = '0;
        add_item(KindLookup, k, 16'h0);
        add_item(KindSpare, '1, 16'h5555);
        add_item(KindSpare, {8'h7A, 184'h0}, 16'h5555);
        add_item(skt_pkg::KindInsert, {64'h0, 64'hFFFF, 64'h1}, 16'h00FF);
        add_item(skt_pkg::KindClear, '1, 16'hFFFF);
        add_item(KindLookup, '1, 16'h0);
        wait_drain();

        // Fill the table to capacity and beyond, distinct keys
        write_missing(16'h0000);
        for (int i = 0; i < skt_pkg::Capacity + 3; i++)
            add_item(skt_pkg::KindInsert, {8'($urandom_range(1, 255)), 8'(i + 1), 176'h0},
                     16'($urandom));
        add_item(KindLookup, {8'h01, 184'h0}, 16'h0);
        wait_drain();

        // Long receiver hold-off while the sender keeps offering
        write_missing(16'hFFFF);
        add_item(skt_pkg::KindClear, '0, 16'h0);
        random_phase(40);
        hold_long = 1'b1;
        wait_drain();
        hold_long = 1'b0;

        write_missing(16'($urandom));
        add_item(skt_pkg::KindClear, '0, 16'h0);
        random_phase(1000);
        wait_drain();
        write_missing(16'd10000);
        random_phase(700);
        wait_drain();
        quiet = 1'b1;
        random_phase(300);
        wait_drain();

        if (errors == 0) $display("sorted_key_table_find_or_insert_core verification clean");
        else $display("sorted_key_table_find_or_insert_core verification failed");
        $finish;
    end

    // Driver: offers beats from the queue, with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || (!o_in_stall_q)) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_items[0];
                    if (!quiet && $urandom_range(0, 9) == 0)
                        src_gap <= $urandom_range(1, 14);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: bursts, or one long hold-off
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_long && hold_left == 0 && !hold_done) begin
                hold_left <= 600;
                hold_done <= 1'b1;
                i_out_stall <= 1'b1;
            end else if (hold_left > 1) begin
                hold_left <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else if (snk_gap > 0) begin
                hold_left <= 0;
                snk_gap <= snk_gap - 1;
                i_out_stall <= 1'b1;
            end else begin
                hold_left <= 0;
                i_out_stall <= 1'b0;
                if (!quiet && $urandom_range(0, 9) == 0)
                    snk_gap <= $urandom_range(1, 14);
            end
        end
    end

    initial begin
        src_gap = 0;
        snk_gap = 0;
        hold_left = 0;
        hold_done = 1'b0;
        o_in_stall_q = 1'b0;
        idle_cycles = 0;
    end

    // Monitor: input accepts feed the predictor, output beats are checked
    always @(posedge i_clk) begin
        skt_pkg::t_out_beat want;
        o_in_stall_q <= o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(table_step(i_in_data));
                void'(pending_items.pop_front());
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data.value_out !== want.value_out)
                        report_mismatch("value_out", o_out_data.value_out, want.value_out);
                    if (o_out_data.status !== want.status)
                        report_mismatch("status", o_out_data.status, want.status);
                    if (o_out_data.count_out !== want.count_out)
                        report_mismatch("count_out", o_out_data.count_out, want.count_out);
                end
            end
            // Watchdog on cycles with no accepted beat
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WatchLimit) begin
                $display("sorted_key_table_find_or_insert_core verification failed");
                $finish;
            end
        end
    end
endmodule

FILE: filelist.f
design/skt_pkg.sv
design/skt_datapath.sv
design/skt_ctrl.sv
design/sorted_key_table_find_or_insert_core.sv
design/skt_checker.sv
tb/testbench.sv
